>>> hw/rtl/dc_pkg.sv
`timescale 1ns / 1ps

package dc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int COUNT_WIDTH = 11;
    localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

    localparam logic [STEP_WIDTH-1:0]  STEP_LAST = STEP_WIDTH'(VALUE_WIDTH - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic advance;
        logic emit;
    } dc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic step_last;
        logic search_done;
    } dc_status_t;

endpackage

>>> hw/rtl/dc_channels.sv
`timescale 1ns / 1ps

interface dc_value_if
    import dc_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface dc_count_if
    import dc_pkg::*;
();
    logic   valid;
    logic   ready;
    count_t divisor_count;

    modport source (output valid, output divisor_count, input ready);
    modport sink (input valid, input divisor_count, output ready);
endinterface

>>> hw/rtl/dc_datapath.sv
`timescale 1ns / 1ps

module dc_datapath
    import dc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dc_cmd_t    cmd,
    input  value_t     value_in,
    output dc_status_t status,
    output count_t     count_out
);

    value_t                  n_reg, n_next;
    value_t                  d_reg, d_next;
    value_t                  rem_reg, rem_next;
    value_t                  quo_reg, quo_next;
    logic [STEP_WIDTH-1:0]   step_reg, step_next;
    count_t                  count_reg, count_next;
    count_t                  result_reg, result_next;

    logic [VALUE_WIDTH:0]    partial;
    logic [VALUE_WIDTH:0]    diff;
    logic                    fits;
    logic [COUNT_WIDTH:0]    sum;
    logic [1:0]              inc;

    // one quotient bit per cycle, restoring
    assign partial = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff    = partial - {1'b0, d_reg};
    assign fits    = partial >= {1'b0, d_reg};

    assign inc = (d_reg == quo_reg) ? 2'd1 : 2'd2;
    assign sum = {1'b0, count_reg} + {{(COUNT_WIDTH-1){1'b0}}, inc};

    always_comb
    begin
        n_next      = n_reg;
        d_next      = d_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            n_next     = value_in;
            d_next     = VALUE_WIDTH'(1);
            rem_next   = '0;
            quo_next   = value_in;
            step_next  = '0;
            count_next = '0;
        end
        else if (cmd.step)
        begin
            rem_next  = fits ? diff[VALUE_WIDTH-1:0] : partial[VALUE_WIDTH-1:0];
            quo_next  = {quo_reg[VALUE_WIDTH-2:0], fits};
            step_next = step_reg + STEP_WIDTH'(1);
        end
        else if (cmd.advance)
        begin
            // rem and quo hold n % d and n / d here
            if (rem_reg == '0)
            begin
                count_next = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
            end
            d_next    = d_reg + VALUE_WIDTH'(1);
            rem_next  = '0;
            quo_next  = n_reg;
            step_next = '0;
        end

        if (cmd.emit)
        begin
            result_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign status.step_last   = (step_reg == STEP_LAST);
    assign status.search_done = (d_reg > quo_reg);
    assign count_out          = result_reg;

endmodule

>>> hw/rtl/dc_controller.sv
`timescale 1ns / 1ps

module dc_controller
    import dc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dc_status_t status,
    output dc_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_EVAL   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.search_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_FINISH:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/divisor_counter.sv
`timescale 1ns / 1ps

// Counts the positive divisors of each item on operand and returns the count on
// result; a value of zero gives zero. Trial divisors d = 1, 2, ... run while
// d <= n / d. For each one, a restoring divider produces one quotient bit per
// cycle, then a separate evaluate state compares and updates the count. One
// item is worked on at a time; a finished count waits in an output register,
// and the next item is taken as soon as it lands there.

module divisor_counter
    import dc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dc_value_if.sink   operand,
    dc_count_if.source result
);

    dc_cmd_t    cmd;
    dc_status_t status;

    dc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operand.valid),
        .in_ready  (operand.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value_in  (operand.value),
        .status    (status),
        .count_out (result.divisor_count)
    );

endmodule

>>> hw/rtl/dc_checker.sv
`timescale 1ns / 1ps

module dc_checker
    import dc_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input count_t out_count
);

    // no result while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an item was taken");

    // the divider has to run first, so no result can follow an item at once
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared right after an item was taken");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_count)))
        else $error("stalled result changed or dropped");

endmodule

bind divisor_counter dc_checker u_dc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_count (result.divisor_count)
);
